>>> rtl/ssw_pkg.sv
// Shared types and constants for the seven-segment two-wire writer.
// Used by ssw_front, ssw_engine, ssw_res_q and the top level; no dependencies.
package ssw_pkg;

	// command kinds, decoded from the op field
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam int VALUE_W = 16;

	// frame bytes
	localparam logic [7:0] BYTE_DATA_CMD = 8'h40;
	localparam logic [7:0] BYTE_ADDR_CMD = 8'hC0;
	localparam logic [7:0] BYTE_DISP_CMD = 8'h88;

	// reciprocal of ten for 16-bit operands: q = (v * 52429) >> 19
	localparam logic [16:0] RECIP_TEN   = 17'd52429;
	localparam int          RECIP_SHIFT = 19;

	typedef struct packed {
		logic               kind;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic clk_line;
		logic dio_line;
		logic busy;
	} res_t;

	// engine status for checking at the top level
	typedef struct packed {
		logic go;
		logic start;
		logic running;
		logic clk_level;
		logic dio_level;
	} eng_sts_t;

	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] code;
		case (digit)
			4'd0: code = 8'b0011_1111;
			4'd1: code = 8'b0000_0110;
			4'd2: code = 8'b0101_1011;
			4'd3: code = 8'b0100_1111;
			4'd4: code = 8'b0110_0110;
			4'd5: code = 8'b0110_1101;
			4'd6: code = 8'b0111_1101;
			4'd7: code = 8'b0000_0111;
			4'd8: code = 8'b0111_1111;
			4'd9: code = 8'b0110_1111;
			default: code = 8'b0000_0000;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/seven_segment_two_wire_writer_top.sv
// Top level of the seven-segment two-wire writer.
// Instantiates ssw_front, ssw_engine and ssw_res_q; depends on ssw_pkg.
//
// Usage:
//   Items enter through push/full with fields op and value. op = 1 starts an
//   update of the lowest NUM_DIGITS decimal digits of value (ignored while
//   busy); op = 0 is a tick that performs one write on the clock/data pins during an update.
//   Every item yields exactly one result (clk_line, dio_line, busy_res),
//   taken through empty/pop in item order.
//   A full update is 125 ticks per digit.
// Timing:
//   One item per cycle sustained while results are popped. A result can be
//   popped once its item is in the result queue: the accepting edge writes
//   the command queue, a later edge carries it through the sequencer into the
//   result queue. The sequencer handles one command a cycle while the result
//   queue has room; the quotient by ten is a registered reciprocal multiply.
// Reset:
//   arst_n clears both queues and the sequencer; its pin levels reset low, not busy.
// Stalls:
//   If pop stays low, the result queue fills, the sequencer halts, the
//   command queue fills and full rises; nothing is lost.
module seven_segment_two_wire_writer_top #(
	parameter int NUM_DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [15:0] value,
	output logic        empty,
	input  logic        pop,
	output logic        clk_line,
	output logic        dio_line,
	output logic        busy_res
);

	logic              cmd_valid;
	ssw_pkg::cmd_t     cmd;
	logic              cmd_pop;
	logic              res_full;
	logic              res_wr;
	ssw_pkg::res_t     res_in;
	ssw_pkg::res_t     res_out;
	ssw_pkg::eng_sts_t sts;

	ssw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.op        (op),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	ssw_engine #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_wr    (res_wr),
		.res       (res_in),
		.sts       (sts)
	);

	ssw_res_q u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (res_wr),
		.wr_data  (res_in),
		.res_full (res_full),
		.empty    (empty),
		.pop      (pop),
		.rd_data  (res_out)
	);

	assign clk_line = res_out.clk_line;
	assign dio_line = res_out.dio_line;
	assign busy_res = res_out.busy;

`ifndef NO_ASSERTIONS
	// a start taken while idle begins an update on the next cycle
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(sts.go && sts.start && !sts.running) |=> sts.running)
		else $error("start while idle did not begin an update");

	// an update always ends on a completed stop condition: both pins high
	a_end_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sts.running) |-> (sts.clk_level && sts.dio_level))
		else $error("update ended without stop condition");

	// the sequencer never produces a result the queue cannot hold
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr && res_full) |-> !cmd_pop)
		else $error("result written into full queue");
`endif

endmodule

>>> rtl/ssw_front.sv
// Front end: accepts items, decodes them into start/tick commands and holds
// them in a two-entry command queue. Depends on ssw_pkg.
module ssw_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        op,
	input  logic [ssw_pkg::VALUE_W-1:0] value,
	output logic                        cmd_valid,
	output ssw_pkg::cmd_t               cmd,
	input  logic                        cmd_pop
);

	ssw_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          wr_en;
	logic          rd_en;
	ssw_pkg::cmd_t decoded;

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;
	assign cmd       = entry_q[rd_ptr_q];

	always_comb begin
		decoded.kind  = op ? ssw_pkg::CMD_START : ssw_pkg::CMD_TICK;
		decoded.value = value;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/ssw_res_q.sv
// Two-entry result queue between the engine and the result port.
// Depends on ssw_pkg.
module ssw_res_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  ssw_pkg::res_t wr_data,
	output logic          res_full,
	output logic          empty,
	input  logic          pop,
	output ssw_pkg::res_t rd_data
);

	ssw_pkg::res_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          wr_en;
	logic          rd_en;

	assign res_full = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign wr_en    = wr && !res_full;
	assign rd_en    = pop && !empty;
	assign rd_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/ssw_engine.sv
// Back end: the frame/byte/bit sequencer that performs one pin write per tick
// during an update and produces one result per command. Depends on ssw_pkg.
module ssw_engine #(
	parameter int NUM_DIGITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  ssw_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_wr,
	output ssw_pkg::res_t     res,
	output ssw_pkg::eng_sts_t sts
);

	localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

	localparam logic [1:0] PART_START = 2'd0;
	localparam logic [1:0] PART_BYTE  = 2'd1;
	localparam logic [1:0] PART_STOP  = 2'd2;

	localparam logic [1:0] FRAME_DATA = 2'd0;
	localparam logic [1:0] FRAME_ADDR = 2'd1;
	localparam logic [1:0] FRAME_DISP = 2'd2;

	localparam int RECIP_SHIFT_END = ssw_pkg::RECIP_SHIFT + 12;

	logic [15:0]      rem_q,   rem_d;
	logic [POS_W-1:0] pos_q,   pos_d;
	logic [1:0]       step_q,  step_d;
	logic [3:0]       bits_q,  bits_d;
	logic [7:0]       shift_q, shift_d;
	logic             clk_q,   clk_d;
	logic             dio_q,   dio_d;
	logic             run_q,   run_d;
	logic [1:0]       frame_q, frame_d;
	logic [1:0]       part_q,  part_d;
	logic             bidx_q,  bidx_d;

	// quotient of rem_q by ten, registered from rem_q; rem_q only changes many
	// ticks before the quotient or the digit is next needed
	logic [32:0] recip_prod;
	logic [12:0] quot_q;
	logic [15:0] quot_x10;
	logic [15:0] digit_full;
	logic [3:0]  digit;
	logic [7:0]  first_byte;
	logic        go;
	logic        is_start;

	assign go       = cmd_valid && !res_full;
	assign cmd_pop  = go;
	assign res_wr   = go;
	assign is_start = (cmd.kind == ssw_pkg::CMD_START);

	assign recip_prod = {17'd0, rem_q} * {16'd0, ssw_pkg::RECIP_TEN};
	assign quot_x10   = {quot_q, 3'b000} + {2'b00, quot_q, 1'b0};
	assign digit_full = rem_q - quot_x10;
	assign digit      = digit_full[3:0];

	always_comb begin
		case (frame_q)
			FRAME_DATA: first_byte = ssw_pkg::BYTE_DATA_CMD;
			FRAME_ADDR: first_byte = ssw_pkg::BYTE_ADDR_CMD + 8'(pos_q);
			default:    first_byte = ssw_pkg::BYTE_DISP_CMD;
		endcase
	end

	always_comb begin
		rem_d   = rem_q;
		pos_d   = pos_q;
		step_d  = step_q;
		bits_d  = bits_q;
		shift_d = shift_q;
		clk_d   = clk_q;
		dio_d   = dio_q;
		run_d   = run_q;
		frame_d = frame_q;
		part_d  = part_q;
		bidx_d  = bidx_q;
		if (go && is_start) begin
			if (!run_q) begin
				rem_d   = cmd.value;
				pos_d   = LAST_POS;
				step_d  = 2'd0;
				bits_d  = 4'd0;
				shift_d = 8'd0;
				frame_d = FRAME_DATA;
				part_d  = PART_START;
				bidx_d  = 1'b0;
				run_d   = 1'b1;
			end
		end else if (go && run_q) begin
			case (part_q)
				PART_START: begin
					case (step_q)
						2'd0: dio_d = 1'b1;
						2'd1: clk_d = 1'b1;
						2'd2: dio_d = 1'b0;
						default: clk_d = 1'b0;
					endcase
					if (step_q == 2'd3) begin
						bidx_d  = 1'b0;
						shift_d = first_byte;
						bits_d  = 4'd0;
						step_d  = 2'd0;
						part_d  = PART_BYTE;
					end else begin
						step_d = step_q + 2'd1;
					end
				end
				PART_BYTE: begin
					if (bits_q < 4'd8) begin
						if (step_q == 2'd0) begin
							dio_d  = shift_q[0];
							step_d = 2'd1;
						end else if (step_q == 2'd1) begin
							clk_d  = 1'b1;
							step_d = 2'd2;
						end else begin
							clk_d   = 1'b0;
							shift_d = {1'b0, shift_q[7:1]};
							bits_d  = bits_q + 4'd1;
							step_d  = 2'd0;
						end
					end else if (step_q == 2'd0) begin
						// acknowledge clock pulse after the data bits; the acknowledge is not sampled
						clk_d  = 1'b1;
						step_d = 2'd1;
					end else begin
						clk_d = 1'b0;
						if (frame_q == FRAME_ADDR && !bidx_q) begin
							bidx_d  = 1'b1;
							shift_d = ssw_pkg::seg_code(digit);
							bits_d  = 4'd0;
							step_d  = 2'd0;
						end else begin
							step_d = 2'd0;
							part_d = PART_STOP;
						end
					end
				end
				default: begin
					if (step_q == 2'd0) begin
						dio_d  = 1'b0;
						step_d = 2'd1;
					end else if (step_q == 2'd1) begin
						clk_d  = 1'b1;
						step_d = 2'd2;
					end else begin
						dio_d  = 1'b1;
						step_d = 2'd0;
						part_d = PART_START;
						bidx_d = 1'b0;
						if (frame_q == FRAME_DISP) begin
							frame_d = FRAME_DATA;
							rem_d   = {3'b000, quot_q};
							if (pos_q == '0) begin
								run_d = 1'b0;
								pos_d = LAST_POS;
							end else begin
								pos_d = pos_q - POS_W'(1);
							end
						end else begin
							frame_d = frame_q + 2'd1;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		quot_q <= recip_prod[RECIP_SHIFT_END:ssw_pkg::RECIP_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			pos_q   <= LAST_POS;
			step_q  <= 2'd0;
			bits_q  <= 4'd0;
			shift_q <= 8'd0;
			clk_q   <= 1'b0;
			dio_q   <= 1'b0;
			run_q   <= 1'b0;
			frame_q <= FRAME_DATA;
			part_q  <= PART_START;
			bidx_q  <= 1'b0;
		end else begin
			rem_q   <= rem_d;
			pos_q   <= pos_d;
			step_q  <= step_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			clk_q   <= clk_d;
			dio_q   <= dio_d;
			run_q   <= run_d;
			frame_q <= frame_d;
			part_q  <= part_d;
			bidx_q  <= bidx_d;
		end
	end

	always_comb begin
		res.clk_line = clk_d;
		res.dio_line = dio_d;
		res.busy     = run_d;
		sts.go        = go;
		sts.start     = is_start;
		sts.running   = run_q;
		sts.clk_level = clk_q;
		sts.dio_level = dio_q;
	end

endmodule

>>> tb/tb_seven_segment_two_wire_writer_top.sv
// Self-checking testbench for seven_segment_two_wire_writer_top: start and tick transactions
// with random idling on both queues, each result checked against a pin-level predictor.
// Depends on ssw_pkg and the writer RTL.

typedef enum logic [1:0] {PH_START, PH_BYTE, PH_STOP} link_phase_t;

class pin_scoreboard;
	ssw_pkg::res_t pin_q[$];
	int            mismatches;
	int            digits;

	// predicted link state
	logic [15:0]   rem_val;
	int            pos;
	int            step;
	int            bit_cnt;
	logic [7:0]    shreg;
	logic          clk_lv;
	logic          dio_lv;
	logic          running;
	int            frame;
	link_phase_t   phase;
	int            byte_idx;

	function new(int n);
		digits     = n;
		mismatches = 0;
		rem_val    = '0;
		pos        = n - 1;
		step       = 0;
		bit_cnt    = 0;
		shreg      = '0;
		clk_lv     = 1'b0;
		dio_lv     = 1'b0;
		running    = 1'b0;
		frame      = 0;
		phase      = PH_START;
		byte_idx   = 0;
	endfunction

	function int pending();
		return pin_q.size();
	endfunction

	function logic [7:0] seg_pattern(int d);
		case (d)
			0: return 8'h3F;
			1: return 8'h06;
			2: return 8'h5B;
			3: return 8'h4F;
			4: return 8'h66;
			5: return 8'h6D;
			6: return 8'h7D;
			7: return 8'h07;
			8: return 8'h7F;
			default: return 8'h6F;
		endcase
	endfunction

	function logic [7:0] opening_byte();
		if (frame == 0)
			return ssw_pkg::BYTE_DATA_CMD;
		if (frame == 1)
			return 8'(ssw_pkg::BYTE_ADDR_CMD + pos);
		return ssw_pkg::BYTE_DISP_CMD;
	endfunction

	function void load_byte(logic [7:0] b);
		shreg   = b;
		bit_cnt = 0;
		step    = 0;
		phase   = PH_BYTE;
	endfunction

	function void close_frame();
		step     = 0;
		phase    = PH_START;
		byte_idx = 0;
		frame++;
		if (frame < 3)
			return;
		frame   = 0;
		rem_val = rem_val / 10;
		if (pos == 0) begin
			running = 1'b0;
			pos     = digits - 1;
		end else begin
			pos--;
		end
	endfunction

	function void pin_write();
		case (phase)
			PH_START: begin
				case (step)
					0: dio_lv = 1'b1;
					1: clk_lv = 1'b1;
					2: dio_lv = 1'b0;
					default: begin
						clk_lv   = 1'b0;
						byte_idx = 0;
						load_byte(opening_byte());
					end
				endcase
				if (phase == PH_START)
					step++;
			end
			PH_BYTE: begin
				if (bit_cnt < 8) begin
					if (step == 0) begin
						dio_lv = shreg[0];
						step   = 1;
					end else if (step == 1) begin
						clk_lv = 1'b1;
						step   = 2;
					end else begin
						clk_lv = 1'b0;
						shreg  = shreg >> 1;
						bit_cnt++;
						step   = 0;
					end
				end else if (step == 0) begin
					// ninth pulse, acknowledge not sampled
					clk_lv = 1'b1;
					step   = 1;
				end else begin
					clk_lv = 1'b0;
					if (frame == 1 && byte_idx == 0) begin
						byte_idx = 1;
						load_byte(seg_pattern(int'(rem_val % 10)));
					end else begin
						step  = 0;
						phase = PH_STOP;
					end
				end
			end
			default: begin
				if (step == 0) begin
					dio_lv = 1'b0;
					step   = 1;
				end else if (step == 1) begin
					clk_lv = 1'b1;
					step   = 2;
				end else begin
					dio_lv = 1'b1;
					close_frame();
				end
			end
		endcase
	endfunction

	// accepted input transaction: advance the prediction, queue the expected pins
	function void note(logic kind, logic [15:0] val);
		ssw_pkg::res_t want;
		if (kind == ssw_pkg::CMD_START) begin
			if (!running) begin
				rem_val  = val;
				pos      = digits - 1;
				step     = 0;
				bit_cnt  = 0;
				shreg    = '0;
				frame    = 0;
				phase    = PH_START;
				byte_idx = 0;
				running  = 1'b1;
			end
		end else if (running) begin
			pin_write();
		end
		want.clk_line = clk_lv;
		want.dio_line = dio_lv;
		want.busy     = running;
		pin_q.push_back(want);
	endfunction

	function void check(ssw_pkg::res_t got);
		ssw_pkg::res_t want;
		if (pin_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result with no transaction outstanding: clk %b dio %b busy %b",
					got.clk_line, got.dio_line, got.busy);
			return;
		end
		want = pin_q.pop_front();
		if (got.clk_line !== want.clk_line || got.dio_line !== want.dio_line ||
				got.busy !== want.busy) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: clk exp %b got %b, dio exp %b got %b, busy exp %b got %b",
					$realtime, want.clk_line, got.clk_line, want.dio_line, got.dio_line,
					want.busy, got.busy);
		end
	endfunction
endclass

module tb_seven_segment_two_wire_writer_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIGITS      = 4;
	localparam int ITEM_GOAL   = 1750;
	localparam int HOLD_CYCLES = 1000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        op;
	logic [15:0] value;
	logic        empty;
	logic        pop;
	logic        clk_line;
	logic        dio_line;
	logic        busy_res;

	pin_scoreboard sb;
	int            items_sent = 0;
	int            results_seen = 0;
	int            tx_calm = 0;
	int            rx_calm = 0;

	seven_segment_two_wire_writer_top #(
		.NUM_DIGITS(DIGITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.op       (op),
		.value    (value),
		.empty    (empty),
		.pop      (pop),
		.clk_line (clk_line),
		.dio_line (dio_line),
		.busy_res (busy_res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// wait before the next transaction; now and then a run with no idling at all
	function automatic int pick_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 5) == 0) begin
			calm = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	task automatic send_item(input logic kind, input logic [15:0] val);
		int gap;
		bit taken;
		gap = pick_wait(tx_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		op    <= kind;
		value <= val;
		// handshake sampled mid-cycle, taken at the following rising edge
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		sb.note(kind, val);
		items_sent++;
	endtask

	// one start then a run of ticks, with the odd start landing while busy
	task automatic run_update(input logic [15:0] val, input int ticks);
		send_item(ssw_pkg::CMD_START, val);
		for (int i = 0; i < ticks; i++) begin
			if ($urandom_range(0, 63) == 0)
				send_item(ssw_pkg::CMD_START, 16'($urandom));
			else
				send_item(ssw_pkg::CMD_TICK, 16'($urandom));
		end
	endtask

	task automatic drain_results();
		int stall;
		bit got;
		ssw_pkg::res_t seen;
		forever begin
			// long hold-offs let the result side back up into the input queue
			if (results_seen == 300 || results_seen == 1200)
				stall = HOLD_CYCLES;
			else
				stall = pick_wait(rx_calm);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do begin
				@(negedge clk);
				got           = !empty;
				seen.clk_line = clk_line;
				seen.dio_line = dio_line;
				seen.busy     = busy_res;
				@(posedge clk);
			end while (!got);
			sb.check(seen);
			results_seen++;
		end
	endtask

	initial begin
		#1_000_000;
		$display("seven_segment_two_wire_writer_top regression: fail");
		$finish;
	end

	initial begin
		logic [15:0] pick;
		int          len;
		sb     = new(DIGITS);
		arst_n = 1'b0;
		push  <= 1'b0;
		pop   <= 1'b0;
		op    <= ssw_pkg::CMD_TICK;
		value <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		fork
			drain_results();
		join_none

		// directed: ticks while idle, extreme value, starts while busy
		send_item(ssw_pkg::CMD_TICK, 16'hFFFF);
		send_item(ssw_pkg::CMD_TICK, 16'h0000);
		send_item(ssw_pkg::CMD_START, 16'hFFFF);
		send_item(ssw_pkg::CMD_START, 16'h0000);
		for (int i = 0; i < 18; i++)
			send_item(ssw_pkg::CMD_TICK, 16'($urandom));
		send_item(ssw_pkg::CMD_START, 16'h5555);

		// full updates first, then a mix of full updates and random lengths
		for (int k = 0; k < 3 || items_sent < ITEM_GOAL; k++) begin
			case (k)
				0: pick = 16'd0;
				1: pick = 16'd9876;
				2: pick = 16'd54321;
				3: pick = 16'd10000;
				default: pick = 16'($urandom);
			endcase
			if (k >= 3 && $urandom_range(0, 4) == 0)
				len = $urandom_range(1, 499);
			else
				len = 500 + $urandom_range(0, 6);
			// trim the last run so the total lands near the goal
			if (k >= 3 && items_sent + len + 1 > ITEM_GOAL)
				len = ITEM_GOAL - items_sent;
			run_update(pick, len);
		end
		push <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("seven_segment_two_wire_writer_top regression: pass");
		else
			$display("seven_segment_two_wire_writer_top regression: fail");
		$finish;
	end

endmodule
